// File: src/sorted_priority_queue_top_defines.svh
// Assertion macros for the sorted priority queue.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int ELEMENT_BITS_DEF  = 16;
  localparam int PRIORITY_BITS_DEF = 16;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT      = 3'd0,
    OP_REMOVE_HEAD = 3'd1,
    OP_REMOVE_ELEM = 3'd2,
    OP_CHANGE_PRIO = 3'd3,
    OP_CONTAINS    = 3'd4,
    OP_CLEAR       = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_REMOVE,
    S_INSERT,
    S_REPORT
  } state_t;

  // Broadcast control for every cell of the chain.
  typedef struct packed {
    logic ins;         // open a gap at the insert point and load the new entry
    logic rem;         // close the gap at the removed entry
    logic check_prio;  // match also on priority
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: src/spq_in_if.sv
// Request channel of the sorted priority queue: valid/ready plus one operation.
// Depends on spq_pkg.
`default_nettype none

interface spq_in_if #(
  parameter int ELEMENT_BITS  = spq_pkg::ELEMENT_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [spq_pkg::OP_W-1:0] operation;
  logic [ELEMENT_BITS-1:0]  element;
  logic [PRIORITY_BITS-1:0] priority_req;
  logic [PRIORITY_BITS-1:0] target_priority;

  modport source (output valid, operation, element, priority_req, target_priority,
                  input ready);
  modport sink   (input valid, operation, element, priority_req, target_priority,
                  output ready);
endinterface

`default_nettype wire

// File: src/spq_out_if.sv
// Response channel of the sorted priority queue: valid/ready plus one result.
// Depends on spq_pkg.
`default_nettype none

interface spq_out_if #(
  parameter int ELEMENT_BITS  = spq_pkg::ELEMENT_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic [spq_pkg::SIZE_W-1:0]   size;
  logic                         head_valid;
  logic [ELEMENT_BITS-1:0]      head_element;
  logic [PRIORITY_BITS-1:0]     head_priority;

  modport source (output valid, status, found, size, head_valid, head_element,
                  head_priority, input ready);
  modport sink   (input valid, status, found, size, head_valid, head_element,
                  head_priority, output ready);
endinterface

`default_nettype wire

// File: src/sorted_priority_queue_top.sv
// Sorted priority queue: chain of slot cells kept in descending priority.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_cell and the defines header.
//
//   channel | dir | payload
//   --------+-----+---------------------------------------------------------
//   req     | in  | operation, element, priority_req, target_priority
//   rsp     | out | status, found, size, head_valid, head_element, head_priority
//
// Sequence: one request at a time. The idle state takes the request; clear and
// unused codes go straight to the report step, insert goes to the insert step
// and the other operations go to the match step. After a match, remove head on
// a non-empty queue and a remove or change that finds its entry take the remove
// step, and a change priority then takes the insert step. Every request ends
// with the report step, which loads the response register; the match, remove
// and insert steps are broadcasts over the cell chain.
// Reset: rst is synchronous; it empties the queue and drops a pending response.
// Stalls: a held response only stalls the report step; a new request is
// taken while the previous response waits in its register.
`default_nettype none
`include "sorted_priority_queue_top_defines.svh"

module sorted_priority_queue_top #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int ELEMENT_BITS  = spq_pkg::ELEMENT_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spq_in_if.sink    req,
  spq_out_if.source rsp
);

  localparam int COUNT_W = $clog2(CAPACITY + 1);

  // Request registers, captured on the request transfer.
  spq_pkg::op_t             op;
  logic [ELEMENT_BITS-1:0]  key_element;
  logic [PRIORITY_BITS-1:0] key_prio;
  logic [PRIORITY_BITS-1:0] new_prio;

  // Control state.
  spq_pkg::state_t  state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  spq_pkg::status_t status, status_next;
  logic             found, found_next;
  logic [CAPACITY-1:0] match_q, match_q_next;
  logic             any_match, any_match_next;

  // Response register.
  logic                     out_valid, out_valid_next;
  logic                     load_out;
  spq_pkg::status_t         out_status;
  logic                     out_found;
  logic [spq_pkg::SIZE_W-1:0] out_size;
  logic                     out_head_valid;
  logic [ELEMENT_BITS-1:0]  out_head_element;
  logic [PRIORITY_BITS-1:0] out_head_priority;

  // Chain wiring.
  spq_pkg::cell_ctl_t       ctl;
  logic [PRIORITY_BITS-1:0] ins_prio;
  logic [CAPACITY-1:0]      occ;
  logic [CAPACITY-1:0]      cell_ge;
  logic [CAPACITY-1:0]      cell_match;
  logic [CAPACITY-1:0]      rm_mask;
  logic [ELEMENT_BITS-1:0]  cell_element [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_prio    [CAPACITY];

  logic req_xfer;

  assign req_xfer  = req.valid && req.ready;
  assign req.ready = (state == spq_pkg::S_IDLE);

  // Change priority matches on the old priority and reinserts at the new one.
  assign ins_prio = (op == spq_pkg::OP_CHANGE_PRIO) ? new_prio : key_prio;

  // Slots from the first match onward pull from their right neighbor:
  // m | -m sets every bit at or above the lowest set bit.
  assign rm_mask = match_q | ((~match_q) + {{(CAPACITY-1){1'b0}}, 1'b1});

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_occ;
    logic                     l_ge;
    logic [ELEMENT_BITS-1:0]  l_element;
    logic [PRIORITY_BITS-1:0] l_prio;
    logic [ELEMENT_BITS-1:0]  r_element;
    logic [PRIORITY_BITS-1:0] r_prio;

    assign occ[i] = (COUNT_W'(i) < count);

    if (i == 0) begin : g_first
      // The head slot always sees an open insert point on its left.
      assign l_occ     = 1'b1;
      assign l_ge      = 1'b1;
      assign l_element = cell_element[0];
      assign l_prio    = cell_prio[0];
    end else begin : g_inner
      assign l_occ     = occ[i-1];
      assign l_ge      = cell_ge[i-1];
      assign l_element = cell_element[i-1];
      assign l_prio    = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // Past the last slot nothing is valid; hold the own value.
      assign r_element = cell_element[i];
      assign r_prio    = cell_prio[i];
    end else begin : g_body
      assign r_element = cell_element[i+1];
      assign r_prio    = cell_prio[i+1];
    end

    spq_cell #(
      .ELEMENT_BITS  (ELEMENT_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk              (clk),
      .ctl              (ctl),
      .occupied         (occ[i]),
      .left_occupied    (l_occ),
      .left_ge          (l_ge),
      .shift_from_right (rm_mask[i]),
      .key_element      (key_element),
      .key_prio         (key_prio),
      .ins_prio         (ins_prio),
      .left_element     (l_element),
      .left_prio        (l_prio),
      .right_element    (r_element),
      .right_prio       (r_prio),
      .element          (cell_element[i]),
      .prio             (cell_prio[i]),
      .ge               (cell_ge[i]),
      .match            (cell_match[i])
    );
  end

  // Capture the request payload.
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      op          <= spq_pkg::op_t'(req.operation);
      key_element <= req.element;
      key_prio    <= req.priority_req;
      new_prio    <= req.target_priority;
    end
  end

  // Next state, cell control and result bookkeeping.
  always_comb begin
    state_next     = state;
    count_next     = count;
    status_next    = status;
    found_next     = found;
    match_q_next   = match_q;
    any_match_next = any_match;
    ctl            = '0;
    load_out       = 1'b0;
    out_valid_next = out_valid && !rsp.ready;

    case (state)
      spq_pkg::S_IDLE: begin
        if (req_xfer) begin
          status_next = spq_pkg::ST_OK;
          found_next  = 1'b0;
          case (spq_pkg::op_t'(req.operation))
            spq_pkg::OP_INSERT:      state_next = spq_pkg::S_INSERT;
            spq_pkg::OP_REMOVE_HEAD,
            spq_pkg::OP_REMOVE_ELEM,
            spq_pkg::OP_CHANGE_PRIO,
            spq_pkg::OP_CONTAINS:    state_next = spq_pkg::S_MATCH;
            spq_pkg::OP_CLEAR: begin
              count_next = '0;
              state_next = spq_pkg::S_REPORT;
            end
            default:                 state_next = spq_pkg::S_REPORT;
          endcase
        end
      end

      spq_pkg::S_MATCH: begin
        // Latch the match vector; remove head targets the head slot.
        if (op == spq_pkg::OP_REMOVE_HEAD) begin
          match_q_next   = {{(CAPACITY-1){1'b0}}, 1'b1};
          any_match_next = (count != '0);
        end else begin
          match_q_next   = cell_match;
          any_match_next = |cell_match;
        end
        state_next = spq_pkg::S_REPORT;
        case (op)
          spq_pkg::OP_CONTAINS: found_next = |cell_match;
          spq_pkg::OP_REMOVE_HEAD: begin
            if (count != '0) state_next = spq_pkg::S_REMOVE;
          end
          spq_pkg::OP_REMOVE_ELEM,
          spq_pkg::OP_CHANGE_PRIO: begin
            if (|cell_match) state_next = spq_pkg::S_REMOVE;
            else             status_next = spq_pkg::ST_MISSING;
          end
          default: state_next = spq_pkg::S_REPORT;
        endcase
      end

      spq_pkg::S_REMOVE: begin
        // Close the gap at the first match.
        ctl.rem    = 1'b1;
        count_next = count - 1'b1;
        state_next = (op == spq_pkg::OP_CHANGE_PRIO) ? spq_pkg::S_INSERT
                                                     : spq_pkg::S_REPORT;
      end

      spq_pkg::S_INSERT: begin
        // Open a gap after the last entry of equal or higher priority.
        if (count == COUNT_W'(CAPACITY)) begin
          status_next = spq_pkg::ST_FULL;
        end else begin
          ctl.ins    = 1'b1;
          count_next = count + 1'b1;
        end
        state_next = spq_pkg::S_REPORT;
      end

      spq_pkg::S_REPORT: begin
        // Hold until the response register is free.
        if (!out_valid || rsp.ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = spq_pkg::S_IDLE;
        end
      end

      default: state_next = spq_pkg::S_IDLE;
    endcase

    ctl.check_prio = (op == spq_pkg::OP_CHANGE_PRIO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      status    <= spq_pkg::ST_OK;
      found     <= 1'b0;
      any_match <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      status    <= status_next;
      found     <= found_next;
      any_match <= any_match_next;
    end
  end

  always_ff @(posedge clk) begin
    match_q <= match_q_next;
  end

  // Response register; head reads as zero when the queue is empty.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status        <= status;
      out_found         <= found;
      out_size          <= spq_pkg::SIZE_W'(count);
      out_head_valid    <= (count != '0);
      out_head_element  <= (count != '0) ? cell_element[0] : '0;
      out_head_priority <= (count != '0) ? cell_prio[0] : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.found         = out_found;
  assign rsp.size          = out_size;
  assign rsp.head_valid    = out_head_valid;
  assign rsp.head_element  = out_head_element;
  assign rsp.head_priority = out_head_priority;

  // Checks on the queue bookkeeping.
  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count <= COUNT_W'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_IMP(a_match_in_range, state == spq_pkg::S_REMOVE, (match_q & ~occ) == '0, "match beyond occupied slots")
  `SPQ_ASSERT_IMP(a_remove_has_match, state == spq_pkg::S_REMOVE, any_match && count != '0, "remove without target")
  `SPQ_ASSERT_NXT(a_remove_dec, state == spq_pkg::S_REMOVE, count == $past(count) - 1'b1, "remove did not drop one entry")
  `SPQ_ASSERT_NXT(a_full_holds, state == spq_pkg::S_INSERT && count == COUNT_W'(CAPACITY), count == $past(count) && status == spq_pkg::ST_FULL, "insert into full queue changed it")

endmodule

`default_nettype wire

// File: src/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast key and shifts toward either neighbor. Depends on spq_pkg.
`default_nettype none

module spq_cell #(
  parameter int ELEMENT_BITS  = spq_pkg::ELEMENT_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctl_t       ctl,
  input  logic                     occupied,
  input  logic                     left_occupied,
  input  logic                     left_ge,
  input  logic                     shift_from_right,
  input  logic [ELEMENT_BITS-1:0]  key_element,
  input  logic [PRIORITY_BITS-1:0] key_prio,
  input  logic [PRIORITY_BITS-1:0] ins_prio,
  input  logic [ELEMENT_BITS-1:0]  left_element,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [ELEMENT_BITS-1:0]  right_element,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  output logic [ELEMENT_BITS-1:0]  element,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic                     ge,
  output logic                     match
);

  logic take_ins;

  assign ge    = (prio >= ins_prio);
  assign match = occupied && (element == key_element) &&
                 (!ctl.check_prio || (prio == key_prio));

  // Act on insert when this slot is at or past the insert point and
  // the chain reaches it (left slot holds an entry).
  assign take_ins = ctl.ins && left_occupied && (!occupied || !ge);

  always_ff @(posedge clk) begin
    if (ctl.rem && shift_from_right) begin
      element <= right_element;
      prio    <= right_prio;
    end else if (take_ins) begin
      if (left_ge) begin
        element <= key_element;
        prio    <= ins_prio;
      end else begin
        element <= left_element;
        prio    <= left_prio;
      end
    end
  end

endmodule

`default_nettype wire

// File: dv/sorted_priority_queue_top_tb.sv
// Testbench for sorted_priority_queue_top: random and directed operations, each
// response checked against an in-bench sorted list. Depends on spq_pkg, spq_in_if,
// spq_out_if and the queue RTL.
`default_nettype none

module sorted_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = spq_pkg::CAPACITY_DEF;
  localparam int EW  = spq_pkg::ELEMENT_BITS_DEF;
  localparam int PW  = spq_pkg::PRIORITY_BITS_DEF;

  // Codes six and seven are not operations; the queue must leave its contents
  // alone and answer with success.
  localparam logic [spq_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [spq_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 8;

  typedef struct {
    logic [spq_pkg::OP_W-1:0] code;
    logic [EW-1:0]   elem;
    logic [PW-1:0]   prio;
    logic [PW-1:0]   nprio;
    bit              drain_first;  // hold until every report is back
  } pq_request_t;

  typedef struct {
    logic [spq_pkg::STATUS_W-1:0] status;
    logic                found;
    logic [spq_pkg::SIZE_W-1:0]   size;
    logic                head_valid;
    logic [EW-1:0]       head_elem;
    logic [PW-1:0]       head_prio;
  } pq_report_t;

  typedef struct {
    logic [EW-1:0] elem;
    logic [PW-1:0] prio;
  } pq_pair_t;

  logic clk;
  logic rst;

  spq_in_if  #(.ELEMENT_BITS(EW), .PRIORITY_BITS(PW)) req_if ();
  spq_out_if #(.ELEMENT_BITS(EW), .PRIORITY_BITS(PW)) rsp_if ();

  sorted_priority_queue_top #(
    .CAPACITY(CAP), .ELEMENT_BITS(EW), .PRIORITY_BITS(PW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  pq_request_t pending_q[$];       // requests not yet transferred
  pq_report_t  queue_reports_q[$]; // predicted reports, oldest first
  pq_pair_t    recent_pairs[$];    // generator's guess at what the queue holds

  int  errors      = 0;
  int  cycle_count = 0;
  int  send_gap    = 0;
  int  stall_left  = 0;
  int  fills_done  = 0;
  bit  req_taken   = 1'b0;

  // Shadow of the queue: slot 0 is the head, descending priority.
  logic [EW-1:0] shadow_elem [CAP];
  logic [PW-1:0] shadow_prio [CAP];
  int            shadow_count = 0;

  // ---------------------------------------------------------------------------
  // Sorted-list predictor
  // ---------------------------------------------------------------------------
  function automatic void shadow_drop(int pos);
    if (pos >= shadow_count) return;
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_elem[i] = shadow_elem[i+1];
      shadow_prio[i] = shadow_prio[i+1];
    end
    shadow_count--;
  endfunction

  // New entry lands behind every entry of greater or equal priority.
  function automatic logic [spq_pkg::STATUS_W-1:0] shadow_put(logic [EW-1:0] e,
                                                             logic [PW-1:0] p);
    int pos;
    pos = 0;
    if (shadow_count >= CAP) return spq_pkg::ST_FULL;
    while (pos < shadow_count && shadow_prio[pos] >= p) pos++;
    for (int i = shadow_count; i > pos; i--) begin
      shadow_elem[i] = shadow_elem[i-1];
      shadow_prio[i] = shadow_prio[i-1];
    end
    shadow_elem[pos] = e;
    shadow_prio[pos] = p;
    shadow_count++;
    return spq_pkg::ST_OK;
  endfunction

  function automatic int shadow_find(logic [EW-1:0] e, bit match_prio, logic [PW-1:0] p);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_elem[i] == e && (!match_prio || shadow_prio[i] == p)) return i;
    return shadow_count;
  endfunction

  function automatic pq_report_t shadow_apply(pq_request_t rq);
    pq_report_t rp;
    int         pos;
    rp.status = spq_pkg::ST_OK;
    rp.found  = 1'b0;
    case (rq.code)
      spq_pkg::OP_INSERT: rp.status = shadow_put(rq.elem, rq.prio);
      spq_pkg::OP_REMOVE_HEAD: if (shadow_count > 0) shadow_drop(0);
      spq_pkg::OP_REMOVE_ELEM: begin
        pos = shadow_find(rq.elem, 1'b0, '0);
        if (pos < shadow_count) shadow_drop(pos);
        else rp.status = spq_pkg::ST_MISSING;
      end
      spq_pkg::OP_CHANGE_PRIO: begin
        pos = shadow_find(rq.elem, 1'b1, rq.prio);
        if (pos < shadow_count) begin
          shadow_drop(pos);
          rp.status = shadow_put(rq.elem, rq.nprio);
        end else begin
          rp.status = spq_pkg::ST_MISSING;
        end
      end
      spq_pkg::OP_CONTAINS: rp.found = (shadow_find(rq.elem, 1'b0, '0) < shadow_count);
      spq_pkg::OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    rp.size       = spq_pkg::SIZE_W'(shadow_count);
    rp.head_valid = (shadow_count > 0);
    rp.head_elem  = (shadow_count > 0) ? shadow_elem[0] : '0;
    rp.head_prio  = (shadow_count > 0) ? shadow_prio[0] : '0;
    return rp;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_req(logic [spq_pkg::OP_W-1:0] code, logic [EW-1:0] e,
                                   logic [PW-1:0] p, logic [PW-1:0] np);
    pq_request_t rq;
    rq.code        = code;
    rq.elem        = e;
    rq.prio        = p;
    rq.nprio       = np;
    rq.drain_first = ($urandom_range(0, 79) == 0);
    pending_q.push_back(rq);
    if (code == spq_pkg::OP_INSERT) begin
      recent_pairs.push_back(pq_pair_t'{elem: e, prio: p});
      if (recent_pairs.size() > 32) void'(recent_pairs.pop_front());
    end else if (code == spq_pkg::OP_CLEAR) begin
      recent_pairs.delete();
    end
  endfunction

  // Mostly a small set of ids so removes and lookups hit, rest fully random.
  function automatic logic [EW-1:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return EW'(1);
      3: return EW'(16'h1234);
      4: return EW'(16'h8000);
      5: return EW'(16'h00ff);
      6: return EW'(16'haaaa);
      default: return EW'($urandom);
    endcase
  endfunction

  // Few distinct priorities so that ties are frequent.
  function automatic logic [PW-1:0] pick_prio();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return PW'(1);
      3: return PW'(2);
      4: return PW'(16'h8000);
      5: return PW'(16'h7fff);
      6: return PW'(3);
      default: return PW'($urandom);
    endcase
  endfunction

  // Change priority aimed at something inserted earlier, if there is one.
  function automatic void push_reprioritize();
    pq_pair_t pr;
    if (recent_pairs.size() > 0 && $urandom_range(0, 3) != 0) begin
      pr = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
      push_req(spq_pkg::OP_CHANGE_PRIO, pr.elem, pr.prio, pick_prio());
    end else begin
      push_req(spq_pkg::OP_CHANGE_PRIO, pick_elem(), pick_prio(), pick_prio());
    end
  endfunction

  function automatic void push_wellformed();
    pq_pair_t pr;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      push_req(spq_pkg::OP_INSERT, pick_elem(), pick_prio(), PW'($urandom));
    end else if (r < 47) begin
      push_req(spq_pkg::OP_REMOVE_HEAD, EW'($urandom), PW'($urandom), PW'($urandom));
    end else if (r < 62) begin
      if (recent_pairs.size() > 0 && $urandom_range(0, 2) != 0) begin
        pr = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
        push_req(spq_pkg::OP_REMOVE_ELEM, pr.elem, PW'($urandom), PW'($urandom));
      end else begin
        push_req(spq_pkg::OP_REMOVE_ELEM, pick_elem(), PW'($urandom), PW'($urandom));
      end
    end else if (r < 80) begin
      push_reprioritize();
    end else if (r < 96) begin
      push_req(spq_pkg::OP_CONTAINS, pick_elem(), PW'($urandom), PW'($urandom));
    end else begin
      push_req(spq_pkg::OP_CLEAR, EW'($urandom), PW'($urandom), PW'($urandom));
    end
  endfunction

  // Mostly short, sometimes medium, rarely long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit calm_stretch();
    return ((cycle_count / 1500) % 3) == 0;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: update on the falling edge, hold until the transfer.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_req
    pq_request_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain_first && queue_reports_q.size() > 0)) begin
        nxt = pending_q.pop_front();
        req_if.valid           <= 1'b1;
        req_if.operation       <= nxt.code;
        req_if.element         <= nxt.elem;
        req_if.priority_req    <= nxt.prio;
        req_if.target_priority <= nxt.nprio;
        send_gap = (!calm_stretch() && $urandom_range(0, 99) < 30) ? idle_len() : 0;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Predict on every request transfer.
  always @(posedge clk) begin : predict_req
    pq_request_t rq;
    if (!rst && req_if.valid && req_if.ready) begin
      rq.code        = req_if.operation;
      rq.elem        = req_if.element;
      rq.prio        = req_if.priority_req;
      rq.nprio       = req_if.target_priority;
      rq.drain_first = 1'b0;
      queue_reports_q.push_back(shadow_apply(rq));
      req_taken = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: random back-pressure, compare every transfer.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      if (!calm_stretch() && $urandom_range(0, 99) < 25) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin : check_rsp
    pq_report_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (queue_reports_q.size() == 0) begin
        $error("response transfer with no request outstanding");
        errors++;
      end else begin
        want = queue_reports_q.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_if.status));
        check_field("found", 32'(want.found), 32'(rsp_if.found));
        check_field("size", 32'(want.size), 32'(rsp_if.size));
        check_field("head_valid", 32'(want.head_valid), 32'(rsp_if.head_valid));
        check_field("head_element", 32'(want.head_elem), 32'(rsp_if.head_element));
        check_field("head_priority", 32'(want.head_prio), 32'(rsp_if.head_priority));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int total;
    int r;

    req_if.valid           = 1'b0;
    req_if.operation       = '0;
    req_if.element         = '0;
    req_if.priority_req    = '0;
    req_if.target_priority = '0;
    rsp_if.ready           = 1'b0;
    rst                    = 1'b1;

    // Empty queue: remove head is a quiet success, the rest miss.
    push_req(spq_pkg::OP_REMOVE_HEAD, '0, '0, '0);
    push_req(spq_pkg::OP_CHANGE_PRIO, '1, '1, '0);
    push_req(spq_pkg::OP_REMOVE_ELEM, '1, '0, '0);
    push_req(spq_pkg::OP_CONTAINS, '0, '0, '0);
    // Extremes, ties at the top priority stay in arrival order.
    push_req(spq_pkg::OP_INSERT, '1, '1, '0);
    push_req(spq_pkg::OP_INSERT, '0, '0, '1);
    push_req(spq_pkg::OP_INSERT, EW'(16'h1234), '1, '0);
    push_req(spq_pkg::OP_INSERT, EW'(16'h5555), PW'(16'h8000), '0);
    push_req(spq_pkg::OP_INSERT, EW'(16'h1234), PW'(16'h8000), '0);
    push_req(spq_pkg::OP_CONTAINS, EW'(16'h1234), '0, '0);
    push_req(spq_pkg::OP_CONTAINS, EW'(16'haaaa), '0, '0);
    // Reprioritize: matching pair moves behind its new equals; a wrong old
    // priority misses even though the element is present.
    push_req(spq_pkg::OP_CHANGE_PRIO, EW'(16'h5555), PW'(16'h8000), '1);
    push_req(spq_pkg::OP_CHANGE_PRIO, EW'(16'h5555), PW'(16'h8000), '0);
    push_req(spq_pkg::OP_CHANGE_PRIO, '0, '0, '0);
    // Remove element takes the first occurrence only.
    push_req(spq_pkg::OP_REMOVE_ELEM, EW'(16'h1234), '0, '0);
    push_req(spq_pkg::OP_CONTAINS, EW'(16'h1234), '0, '0);
    push_req(spq_pkg::OP_REMOVE_ELEM, EW'(16'h4321), '0, '0);
    push_req(OP_SPARE_A, '1, '1, '1);
    push_req(OP_SPARE_B, '0, '0, '0);
    push_req(spq_pkg::OP_REMOVE_HEAD, '0, '0, '0);
    push_req(spq_pkg::OP_CLEAR, '1, '1, '1);
    push_req(spq_pkg::OP_CONTAINS, '1, '0, '0);
    pending_q[pending_q.size() - 1].drain_first = 1'b1;

    total = pending_q.size() + RANDOM_ITEMS;
    while (pending_q.size() < total) begin
      r = $urandom_range(0, 99);
      if (r < 6 && fills_done < 3) begin
        // Fill past capacity with few priorities, work while full, then go on with random operations.
        fills_done++;
        push_req(spq_pkg::OP_CLEAR, EW'($urandom), PW'($urandom), PW'($urandom));
        for (int i = 0; i < CAP + 3; i++)
          push_req(spq_pkg::OP_INSERT, pick_elem(), PW'($urandom_range(0, 3)),
                   PW'($urandom));
        for (int i = 0; i < 6; i++) begin
          push_reprioritize();
          push_req(spq_pkg::OP_CONTAINS, pick_elem(), PW'($urandom), PW'($urandom));
        end
        for (int i = 0; i < 8; i++) push_wellformed();
      end else if (r < 88) begin
        for (int i = 0; i < 10; i++) push_wellformed();
      end else begin
        // Noise: any code, any field value.
        for (int i = 0; i < 5; i++)
          push_req(spq_pkg::OP_W'($urandom_range(0, 7)), EW'($urandom), PW'($urandom),
                   PW'($urandom));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_q.size() > 0 || req_if.valid || queue_reports_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (queue_reports_q.size() > 0) begin
      $error("%0d reports never arrived", queue_reports_q.size());
      errors++;
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
